FILE: src/pst80_pkg.sv
// shared types, constants and round functions for the 80-bit-key block cipher
// no dependencies; every other file depends on this package
package pst80_pkg;

  localparam int BLK_W = 64;
  localparam int KEY_W = 80;
  localparam int KEY_HI_W = 64;
  localparam int KEY_LO_W = 16;
  localparam int RND_W = 5;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 8'd1;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [RND_W-1:0] rnd_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // substitution over all 16 nibbles
  function automatic blk_t sub_layer(input blk_t x);
    blk_t y;
    y = '0;
    for (int n = 0; n < 16; n++) begin
      y[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // bit i moves to 16*i mod 63, top bit stays
  function automatic blk_t perm_layer(input blk_t x);
    blk_t y;
    y = '0;
    for (int i = 0; i < 63; i++) begin
      y[(16 * i) % 63] = x[i];
    end
    y[63] = x[63];
    return y;
  endfunction

  // key schedule step: rotate left by 61, s-box on top nibble, round count into bits 19..15
  function automatic key_t next_key(input key_t k, input rnd_t rnd);
    key_t t;
    t = {k[18:0], k[79:19]};
    t[79:76] = SBOX[t[79:76]];
    t[19:15] = t[19:15] ^ rnd;
    return t;
  endfunction

endpackage

FILE: src/pst80_if.sv
// stream and configuration channel interfaces for the cipher block
// depends on pst80_pkg for payload widths
interface pst80_plain_if;
  logic valid;
  logic ready;
  logic [pst80_pkg::BLK_W-1:0] plain_block;
  modport source (output valid, output plain_block, input ready);
  modport sink (input valid, input plain_block, output ready);
endinterface

interface pst80_cipher_if;
  logic valid;
  logic ready;
  logic [pst80_pkg::BLK_W-1:0] cipher_block;
  modport source (output valid, output cipher_block, input ready);
  modport sink (input valid, input cipher_block, output ready);
endinterface

interface pst80_cfg_if;
  logic valid;
  logic ready;
  logic [pst80_pkg::CFG_IDX_W-1:0] index;
  logic [pst80_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/pst80_round.sv
// one pipeline stage: a full cipher round plus the matching key schedule step
// depends on pst80_pkg for the round functions
module pst80_round #(
  parameter logic [4:0] ROUND_NUM = 5'd1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pst80_pkg::blk_t       in_data,
  input  pst80_pkg::key_t       in_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pst80_pkg::blk_t       out_data,
  output pst80_pkg::key_t       out_key
);
  import pst80_pkg::*;

  logic valid;
  blk_t data;
  key_t key;

  // stage takes a new item when empty or when its content moves on
  assign in_ready = !valid || out_ready;

  // stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // round datapath: key add, substitution, bit permutation
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= perm_layer(sub_layer(in_data ^ in_key[KEY_W-1 -: KEY_HI_W]));
      key  <= next_key(in_key, ROUND_NUM);
    end
  end

  assign out_valid = valid;
  assign out_data  = data;
  assign out_key   = key;

endmodule

FILE: src/present80_block_encrypt.sv
// top level of the 80-bit-key block cipher encryption pipeline
// depends on pst80_pkg, the channel interfaces and pst80_round
//
// Encrypts one 64-bit block per clock while the output is not stalled. Each
// of the ROUNDS rounds is one register stage (key add, s-box layer, bit
// permutation, key schedule step), and a final output register applies the
// key whitening, so a block passes through every round stage and then the
// output register before it is offered at the output. The
// key is written through the configuration channel (index 0: key bits 79..16,
// index 1: key bits 15..0, other indexes ignored) and must only be changed
// while no block is in flight. Stalls are absorbed stage by stage: empty
// stages keep taking input while a finished block waits at the output.
module present80_block_encrypt #(
  parameter int ROUNDS = 31
) (
  input  logic clk,
  input  logic rst,
  pst80_cfg_if.sink      cfg,
  pst80_plain_if.sink    plain,
  pst80_cipher_if.source cipher
);
  import pst80_pkg::*;

  logic [KEY_HI_W-1:0] key_upper;
  logic [KEY_LO_W-1:0] key_lower;

  logic stage_valid [ROUNDS+1];
  logic stage_ready [ROUNDS+1];
  blk_t stage_data  [ROUNDS+1];
  key_t stage_key   [ROUNDS+1];

  logic cipher_valid;
  blk_t cipher_data;
  logic last_ready;

  // key registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_UPPER: key_upper <= cfg.data;
        REG_KEY_LOWER: key_lower <= cfg.data[KEY_LO_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline input
  assign stage_valid[0] = plain.valid;
  assign stage_data[0]  = plain.plain_block;
  assign stage_key[0]   = {key_upper, key_lower};
  assign plain.ready    = stage_ready[0];

  // round stages
  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    pst80_round #(
      .ROUND_NUM(RND_W'(r))
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r-1]),
      .in_ready  (stage_ready[r-1]),
      .in_data   (stage_data[r-1]),
      .in_key    (stage_key[r-1]),
      .out_valid (stage_valid[r]),
      .out_ready (stage_ready[r]),
      .out_data  (stage_data[r]),
      .out_key   (stage_key[r])
    );
  end

  // output register with final key whitening
  assign last_ready = !cipher_valid || cipher.ready;
  assign stage_ready[ROUNDS] = last_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (last_ready) begin
      cipher_valid <= stage_valid[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && stage_valid[ROUNDS]) begin
      cipher_data <= stage_data[ROUNDS] ^ stage_key[ROUNDS][KEY_W-1 -: KEY_HI_W];
    end
  end

  assign cipher.valid        = cipher_valid;
  assign cipher.cipher_block = cipher_data;

endmodule

FILE: src/pst80_checker.sv
// port-level checks on the cipher pipeline and the bind that attaches them
// depends on pst80_pkg and present80_block_encrypt
module pst80_port_checks #(
  parameter int DEPTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  plain_valid,
  input logic                  plain_ready,
  input logic                  cipher_valid,
  input logic                  cipher_ready,
  input pst80_pkg::blk_t       cipher_block
);
  import pst80_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] in_flight;
  logic             plain_xfer;
  logic             cipher_xfer;

  assign plain_xfer  = plain_valid && plain_ready;
  assign cipher_xfer = cipher_valid && cipher_ready;

  // blocks taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (plain_xfer && !cipher_xfer) begin
      in_flight <= in_flight + 1'b1;
    end else if (cipher_xfer && !plain_xfer) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // a result is only offered for a block that was taken in
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    cipher_valid |-> (in_flight != '0))
    else $error("result offered with no block in flight");

  // an empty output stage means every round stage can move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !cipher_valid |-> plain_ready)
    else $error("input stalled while output is empty");

  // in-flight count never exceeds the pipeline depth
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(DEPTH))
    else $error("more blocks in flight than pipeline stages");

  // a stalled result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && !cipher_ready |=> cipher_valid && $stable(cipher_block))
    else $error("stalled result dropped or changed");

endmodule

bind present80_block_encrypt pst80_port_checks #(
  .DEPTH(ROUNDS + 1)
) u_pst80_checker (
  .clk          (clk),
  .rst          (rst),
  .plain_valid  (plain.valid),
  .plain_ready  (plain.ready),
  .cipher_valid (cipher.valid),
  .cipher_ready (cipher.ready),
  .cipher_block (cipher.cipher_block)
);
